// ===== design/lfi_pkg.sv =====
// ----------------------------------------------------------------------------
// lfi_pkg
// Shared types, constants and helpers of the Lagrangian flux interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfi_pkg;

  localparam int MAX_PENCIL = 64;
  localparam int CNT_W      = $clog2(MAX_PENCIL);
  localparam int POS_W      = 6;
  localparam int DATA_W     = 32;
  localparam int Q_DEPTH    = 4;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = CFG_IDX_W'(1);

  // ceil(2^19 / 3): exact quotient for 18-bit dividends
  localparam logic [17:0] RECIP3 = 18'd174763;

  // one flux job handed from the front to the back
  typedef struct packed {
    logic signed [DATA_W-1:0] fm1;
    logic signed [DATA_W-1:0] f0;
    logic signed [DATA_W-1:0] fp1;
    logic signed [DATA_W-1:0] fp2;
    logic signed [DATA_W-1:0] g0;
    logic signed [DATA_W-1:0] g1;
    logic signed [DATA_W-1:0] sh;
    logic                     calc;
    logic                     mode;
    logic [CNT_W-1:0]         pos;
    logic                     last;
  } lfi_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lfi_qstat_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MUL, B_CHK, B_DIV, B_MLO, B_MHI, B_RND, B_DIV3, B_ACC, B_DONE
  } lfi_bstate_e;

  typedef enum logic [1:0] {
    DIV_BY_ONE, DIV_BY_TWO, DIV_BY_TWELVE, DIV_BY_TWENTY_FOUR
  } lfi_dsel_e;

  typedef enum logic [1:0] {
    DEST_ACC, DEST_P2, DEST_P3, DEST_P4
  } lfi_dest_e;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [44:0] v);
    if (v > 45'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -45'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== design/lfi_front.sv =====
// ----------------------------------------------------------------------------
// lfi_front
// Takes pencil elements, keeps the sample/grid/shift window and turns each
// element into zero to three flux jobs, one per cycle while the queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfi_front import lfi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     mode_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic signed [DATA_W-1:0] grid_pos_i,
  input  logic signed [DATA_W-1:0] shift_i,
  input  logic                     last_in_i,
  input  lfi_qstat_t               qstat_i,
  output logic                     push_o,
  output lfi_job_t                 job_o
);

  logic signed [DATA_W-1:0] sw_q [3];
  logic signed [DATA_W-1:0] gw_q [2];
  logic signed [DATA_W-1:0] shw_q [2];
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  logic signed [DATA_W-1:0] snap_sw_q [3];
  logic signed [DATA_W-1:0] snap_gw_q [2];
  logic signed [DATA_W-1:0] snap_shw_q [2];
  logic signed [DATA_W-1:0] snap_f_q, snap_g_q;
  logic [CNT_W-1:0]         snap_k_q;
  logic                     snap_mode_q;
  // bit 0: interior flux k-2, bit 1: flush flux k-1, bit 2: closing flux k
  logic [2:0]               pend_q, pend_d;

  logic accept, last_el;

  assign in_stall_o = |pend_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign last_el    = last_in_i || (cnt_q >= CNT_W'(MAX_PENCIL - 1));
  assign cnt_d      = last_el ? '0 : cnt_q + CNT_W'(1);

  always_comb begin
    job_o  = '0;
    push_o = 1'b0;
    pend_d = pend_q;
    if (accept) begin
      pend_d = {last_el, last_el && (cnt_q >= CNT_W'(1)), cnt_q >= CNT_W'(2)};
    end else if (!qstat_i.full) begin
      priority if (pend_q[0]) begin
        push_o    = 1'b1;
        pend_d[0] = 1'b0;
        job_o.fm1 = snap_sw_q[2];
        job_o.f0  = snap_sw_q[1];
        job_o.fp1 = snap_sw_q[0];
        job_o.fp2 = snap_f_q;
        job_o.g0  = snap_gw_q[1];
        job_o.g1  = snap_gw_q[0];
        job_o.sh  = snap_shw_q[1];
        job_o.calc = snap_mode_q ? (snap_k_q >= CNT_W'(4)) : (snap_k_q >= CNT_W'(3));
        job_o.pos = snap_k_q - CNT_W'(2);
      end else if (pend_q[1]) begin
        push_o    = 1'b1;
        pend_d[1] = 1'b0;
        job_o.fm1 = snap_sw_q[1];
        job_o.f0  = snap_sw_q[0];
        job_o.fp1 = snap_f_q;
        job_o.g0  = snap_gw_q[0];
        job_o.g1  = snap_g_q;
        job_o.sh  = snap_shw_q[0];
        // fourth order never reaches the flush index
        job_o.calc = !snap_mode_q && (snap_k_q >= CNT_W'(2));
        job_o.pos = snap_k_q - CNT_W'(1);
      end else if (pend_q[2]) begin
        push_o     = 1'b1;
        pend_d[2]  = 1'b0;
        job_o.pos  = snap_k_q;
        job_o.last = 1'b1;
      end
    end
    job_o.mode = snap_mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
      for (int i = 0; i < 3; i++) sw_q[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        gw_q[i]  <= '0;
        shw_q[i] <= '0;
      end
    end else begin
      pend_q <= pend_d;
      if (accept) begin
        cnt_q    <= cnt_d;
        sw_q[2]  <= sw_q[1];
        sw_q[1]  <= sw_q[0];
        sw_q[0]  <= sample_i;
        gw_q[1]  <= gw_q[0];
        gw_q[0]  <= grid_pos_i;
        shw_q[1] <= shw_q[0];
        shw_q[0] <= shift_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) snap_sw_q[i] <= sw_q[i];
      for (int i = 0; i < 2; i++) begin
        snap_gw_q[i]  <= gw_q[i];
        snap_shw_q[i] <= shw_q[i];
      end
      snap_f_q    <= sample_i;
      snap_g_q    <= grid_pos_i;
      snap_k_q    <= cnt_q;
      snap_mode_q <= mode_i;
    end
  end

endmodule

// ===== design/lfi_queue.sv =====
// ----------------------------------------------------------------------------
// lfi_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfi_queue import lfi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lfi_job_t   job_i,
  input  logic       pop_i,
  output lfi_job_t   job_o,
  output lfi_qstat_t qstat_o
);

  lfi_job_t          mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign qstat_o.full  = (cnt_q == (QPTR_W+1)'(Q_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign job_o         = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPTR_W'(1);
      if (do_pop)  rd_q <= rd_q + QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

endmodule

// ===== design/lfi_back.sv =====
// ----------------------------------------------------------------------------
// lfi_back
// Flux engine: Courant factor by restoring division, then powers and
// stencil terms through one shared split multiplier and a radix-2^16
// divide-by-three, summed and saturated into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfi_back import lfi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [DATA_W-1:0]        time_step_i,
  input  lfi_job_t                 job_i,
  input  lfi_qstat_t               qstat_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] flux_o,
  output logic [POS_W-1:0]         position_o,
  output logic                     zero_spacing_o,
  output logic                     last_out_o
);

  lfi_bstate_e state_q, state_d;

  logic               mode_q, mode_d, last_q, last_d, zero_q, zero_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic               sc_q, sc_d;
  logic [32:0]        dx_q, dx_d;
  logic [31:0]        shmag_q, shmag_d;
  logic [63:0]        num_q, num_d;
  logic [30:0]        feed_q, feed_d;
  logic [32:0]        rem_q, rem_d;
  logic [30:0]        quo_q, quo_d;
  logic [4:0]         dcnt_q, dcnt_d;
  logic [33:0]        p1_q, p1_d, p2_q, p2_d, p3_q, p3_d, p4_q, p4_d;
  logic signed [37:0] s0_q, s0_d, s1_q, s1_d, s2_q, s2_d, s3_q, s3_d;
  logic [2:0]         op_q, op_d;
  logic [70:0]        prod_q, prod_d;
  logic [41:0]        val_q, val_d;
  logic [47:0]        x3_q, x3_d, q3_q, q3_d;
  logic [1:0]         r3_q, r3_d, c3_q, c3_d;
  logic signed [44:0] acc_q, acc_d;

  logic                     ovld_q, ovld_d, ozero_q, ozero_d, olast_q, olast_d;
  logic signed [DATA_W-1:0] oflux_q, oflux_d;
  logic [CNT_W-1:0]         opos_q, opos_d;

  // load-time values from the queue head
  logic signed [32:0] gdiff;
  logic [32:0]        ldx;
  logic signed [37:0] efm1, ef0, efp1, efp2;

  // operand selection of the current term
  logic [33:0]        a_mag;
  logic               a_neg, b_neg;
  logic signed [37:0] b_sum;
  logic [36:0]        b_mag;
  lfi_dsel_e          dsel;
  lfi_dest_e          dest;
  logic               use_sum;
  logic [2:0]         last_op;

  // shared datapath pieces
  logic [33:0] trial;
  logic [52:0] mul_lo;
  logic [51:0] mul_hi;
  logic [71:0] rnd_sum;
  logic [41:0] mval;
  logic [17:0] xdig;
  logic [35:0] prod3;
  logic [15:0] qdig;
  logic [17:0] rdig;
  logic signed [44:0] sval;
  logic out_free;

  assign gdiff = 33'(job_i.g1) - 33'(job_i.g0);
  assign ldx   = gdiff[32] ? 33'(-gdiff) : 33'(gdiff);
  assign efm1  = 38'(job_i.fm1);
  assign ef0   = 38'(job_i.f0);
  assign efp1  = 38'(job_i.fp1);
  assign efp2  = 38'(job_i.fp2);

  assign last_op = mode_q ? 3'd6 : 3'd2;

  always_comb begin
    a_mag   = p1_q;
    a_neg   = sc_q;
    b_sum   = s0_q;
    use_sum = 1'b0;
    dsel    = DIV_BY_ONE;
    dest    = DEST_ACC;
    if (!mode_q) begin
      unique case (op_q)
        3'd0: dest = DEST_P2;
        3'd1: begin
          use_sum = 1'b1;
          dsel    = DIV_BY_TWO;
        end
        3'd2: begin
          a_mag   = p2_q;
          a_neg   = 1'b0;
          b_sum   = s1_q;
          use_sum = 1'b1;
          dsel    = DIV_BY_TWO;
        end
        default: dest = DEST_ACC;
      endcase
    end else begin
      unique case (op_q)
        3'd0: dest = DEST_P2;
        3'd1: begin
          a_mag = p2_q;
          a_neg = 1'b0;
          dest  = DEST_P3;
        end
        3'd2: begin
          a_mag = p3_q;
          dest  = DEST_P4;
        end
        3'd3: begin
          use_sum = 1'b1;
          dsel    = DIV_BY_TWELVE;
        end
        3'd4: begin
          a_mag   = p2_q;
          a_neg   = 1'b0;
          b_sum   = s1_q;
          use_sum = 1'b1;
          dsel    = DIV_BY_TWENTY_FOUR;
        end
        3'd5: begin
          a_mag   = p3_q;
          b_sum   = s2_q;
          use_sum = 1'b1;
          dsel    = DIV_BY_TWELVE;
        end
        3'd6: begin
          a_mag   = p4_q;
          a_neg   = 1'b0;
          b_sum   = s3_q;
          use_sum = 1'b1;
          dsel    = DIV_BY_TWENTY_FOUR;
        end
        default: dest = DEST_ACC;
      endcase
    end
    if (use_sum) begin
      b_neg = b_sum[37];
      b_mag = b_sum[37] ? 37'(-b_sum) : b_sum[36:0];
    end else begin
      b_neg = sc_q;
      b_mag = 37'(p1_q);
    end
  end

  assign trial   = {rem_q, feed_q[30]};
  assign mul_lo  = a_mag * b_mag[18:0];
  assign mul_hi  = a_mag * b_mag[36:19];
  assign rnd_sum = 72'(prod_q) + 72'(32'h2000_0000);
  assign mval    = rnd_sum[71:30];
  assign xdig    = {r3_q, x3_q[47:32]};
  assign prod3   = xdig * RECIP3;
  assign qdig    = prod3[34:19];
  assign rdig    = xdig - 18'(qdig) * 18'd3;
  assign sval    = (a_neg ^ b_neg) ? -$signed({3'b0, val_q}) : $signed({3'b0, val_q});
  assign out_free = !ovld_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = (job_i.calc && (ldx != '0)) ? B_MUL : B_DONE;
        end
      end
      B_MUL: state_d = B_CHK;
      B_CHK: state_d = (num_q >= {14'b0, dx_q, 17'b0}) ? B_MLO : B_DIV;
      B_DIV: if (dcnt_q == '0) state_d = B_MLO;
      B_MLO: state_d = B_MHI;
      B_MHI: state_d = B_RND;
      B_RND: begin
        state_d = ((dsel == DIV_BY_ONE) || (dsel == DIV_BY_TWO)) ? B_ACC : B_DIV3;
      end
      B_DIV3: if (c3_q == '0) state_d = B_ACC;
      B_ACC:  state_d = (op_q == last_op) ? B_DONE : B_MLO;
      B_DONE: if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_d = mode_q; last_d = last_q; zero_d = zero_q; pos_d = pos_q;
    sc_d = sc_q; dx_d = dx_q; shmag_d = shmag_q;
    num_d = num_q; feed_d = feed_q; rem_d = rem_q; quo_d = quo_q; dcnt_d = dcnt_q;
    p1_d = p1_q; p2_d = p2_q; p3_d = p3_q; p4_d = p4_q;
    s0_d = s0_q; s1_d = s1_q; s2_d = s2_q; s3_d = s3_q;
    op_d = op_q; prod_d = prod_q; val_d = val_q;
    x3_d = x3_q; q3_d = q3_q; r3_d = r3_q; c3_d = c3_q; acc_d = acc_q;
    ovld_d = ovld_q && out_stall_i;
    oflux_d = oflux_q; opos_d = opos_q; ozero_d = ozero_q; olast_d = olast_q;
    pop_o = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          mode_d  = job_i.mode;
          last_d  = job_i.last;
          pos_d   = job_i.pos;
          zero_d  = job_i.calc && (ldx == '0);
          sc_d    = job_i.sh[31];
          dx_d    = ldx;
          shmag_d = job_i.sh[31] ? (~job_i.sh + 32'd1) : job_i.sh;
          acc_d   = '0;
          op_d    = '0;
          if (!job_i.mode) begin
            s0_d = efp1 + ef0;
            s1_d = ef0 - efp1;
            s2_d = '0;
            s3_d = '0;
          end else begin
            s0_d = -efp2 + 38'sd7 * efp1 + 38'sd7 * ef0 - efm1;
            s1_d = efp2 - 38'sd15 * efp1 + 38'sd15 * ef0 - efm1;
            s2_d = efp2 - efp1 - ef0 + efm1;
            s3_d = -efp2 + 38'sd3 * efp1 - 38'sd3 * ef0 + efm1;
          end
        end
      end
      B_MUL: num_d = 64'(shmag_q) * 64'(time_step_i);
      B_CHK: begin
        if (num_q >= {14'b0, dx_q, 17'b0}) begin
          p1_d = 34'h0_7FFF_FFFF;
        end else begin
          rem_d  = num_q[49:17];
          feed_d = {num_q[16:0], 14'b0};
          quo_d  = '0;
          dcnt_d = 5'd30;
        end
      end
      B_DIV: begin
        if (trial >= {1'b0, dx_q}) begin
          rem_d = 33'(trial - {1'b0, dx_q});
          quo_d = {quo_q[29:0], 1'b1};
        end else begin
          rem_d = trial[32:0];
          quo_d = {quo_q[29:0], 1'b0};
        end
        feed_d = {feed_q[29:0], 1'b0};
        dcnt_d = dcnt_q - 5'd1;
        if (dcnt_q == '0) p1_d = 34'(quo_d);
      end
      B_MLO: prod_d = 71'(mul_lo);
      B_MHI: prod_d = prod_q + {mul_hi, 19'b0};
      B_RND: begin
        r3_d = '0;
        q3_d = '0;
        c3_d = 2'd2;
        unique case (dsel)
          DIV_BY_ONE:         val_d = mval;
          DIV_BY_TWO:         val_d = (mval + 42'd1) >> 1;
          DIV_BY_TWELVE:      x3_d  = 48'((mval + 42'd6) >> 2);
          DIV_BY_TWENTY_FOUR: x3_d  = 48'((mval + 42'd12) >> 3);
          default:            val_d = mval;
        endcase
      end
      B_DIV3: begin
        q3_d = {q3_q[31:0], qdig};
        r3_d = rdig[1:0];
        x3_d = {x3_q[31:0], 16'b0};
        c3_d = c3_q - 2'd1;
        if (c3_q == '0) val_d = q3_d[41:0];
      end
      B_ACC: begin
        unique case (dest)
          DEST_ACC: acc_d = acc_q + sval;
          DEST_P2:  p2_d  = val_q[33:0];
          DEST_P3:  p3_d  = val_q[33:0];
          DEST_P4:  p4_d  = val_q[33:0];
          default:  acc_d = acc_q;
        endcase
        op_d = op_q + 3'd1;
      end
      B_DONE: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          oflux_d = sat32(acc_q);
          opos_d  = pos_q;
          ozero_d = zero_q;
          olast_d = last_q;
        end
      end
      default: ovld_d = ovld_q && out_stall_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; last_q <= last_d; zero_q <= zero_d; pos_q <= pos_d;
    sc_q <= sc_d; dx_q <= dx_d; shmag_q <= shmag_d;
    num_q <= num_d; feed_q <= feed_d; rem_q <= rem_d; quo_q <= quo_d;
    dcnt_q <= dcnt_d;
    p1_q <= p1_d; p2_q <= p2_d; p3_q <= p3_d; p4_q <= p4_d;
    s0_q <= s0_d; s1_q <= s1_d; s2_q <= s2_d; s3_q <= s3_d;
    op_q <= op_d; prod_q <= prod_d; val_q <= val_d;
    x3_q <= x3_d; q3_q <= q3_d; r3_q <= r3_d; c3_q <= c3_d; acc_q <= acc_d;
    oflux_q <= oflux_d; opos_q <= opos_d; ozero_q <= ozero_d; olast_q <= olast_d;
  end

  assign out_valid_o    = ovld_q;
  assign flux_o         = oflux_q;
  assign position_o     = POS_W'(opos_q);
  assign zero_spacing_o = ozero_q;
  assign last_out_o     = olast_q;

endmodule

// ===== design/lagrangian_flux_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// lagrangian_flux_interpolator_top
// Streaming second/fourth order Lagrangian flux interpolator, one pencil at
// a time.
// ----------------------------------------------------------------------------
// Each element yields one flux, delayed by two elements; the element marked
// last flushes the rest of the pencil. The front takes one element whenever
// its previous one has pushed its jobs into a four-entry job queue, one per
// cycle while the queue has room. The back computes one job at a time: edge
// and zero-spacing fluxes skip the arithmetic; a computed flux runs through
// the one-bit-per-cycle Courant divider, then the shared split multiplier
// with its divide-by-three unit, for more terms in fourth than second order.
// The result register lets the next job run while a result is stalled.
// Write order_mode and time_step only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lagrangian_flux_interpolator_top import lfi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic signed [DATA_W-1:0] grid_pos_i,
  input  logic signed [DATA_W-1:0] shift_i,
  input  logic                     last_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] flux_o,
  output logic [POS_W-1:0]         position_o,
  output logic                     zero_spacing_o,
  output logic                     last_out_o
);

  logic              order_mode_q;
  logic [DATA_W-1:0] time_step_q;
  lfi_job_t          fjob, qjob;
  lfi_qstat_t        qstat;
  logic              push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q <= 1'b0;
      time_step_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORDER_MODE: order_mode_q <= cfg_data_i[0];
        REG_TIME_STEP:  time_step_q  <= cfg_data_i;
        default:        order_mode_q <= order_mode_q;
      endcase
    end
  end

  lfi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (order_mode_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .grid_pos_i (grid_pos_i),
    .shift_i    (shift_i),
    .last_in_i  (last_in_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .job_o      (fjob)
  );

  lfi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (fjob),
    .pop_i   (pop),
    .job_o   (qjob),
    .qstat_o (qstat)
  );

  lfi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .time_step_i    (time_step_q),
    .job_i          (qjob),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .flux_o         (flux_o),
    .position_o     (position_o),
    .zero_spacing_o (zero_spacing_o),
    .last_out_o     (last_out_o)
  );

endmodule

// ===== design/lfi_checker.sv =====
// ----------------------------------------------------------------------------
// lfi_checker
// Port-level checks of the flux interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfi_checker import lfi_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] flux_o,
  input logic [POS_W-1:0]         position_o,
  input logic                     zero_spacing_o,
  input logic                     last_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(flux_o) && $stable(position_o))
    else $error("stalled result changed");

  a_zero_flux: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_spacing_o |-> flux_o == '0)
    else $error("zero spacing with nonzero flux");

  a_last_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_out_o |-> flux_o == '0 && !zero_spacing_o)
    else $error("closing flux not zero");

  a_first_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && position_o == '0 |-> flux_o == '0 && !zero_spacing_o)
    else $error("edge index zero gave a flux");

endmodule

bind lagrangian_flux_interpolator_top lfi_checker u_lfi_checker (.*);
